/* rtl/cbez_pkg.sv */
// ============================================================================
// cbez_pkg: shared types and constants for the cubic Bezier point evaluator
// Widths of the parameter, weight and coordinate paths and the register map.
// ============================================================================
package cbez_pkg;

    localparam int T_W     = 17;
    localparam int COORD_W = 16;
    localparam int W_W     = 49;
    localparam int PROD_W  = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [T_W-1:0]    ONE_Q16    = 17'd65536;
    localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } t_reg_idx;

    typedef logic [3:0][COORD_W-1:0] t_coord4;
    typedef logic [3:0][W_W-1:0]     t_weights;

    typedef struct packed {
        t_coord4 x;
        t_coord4 y;
    } t_ctrl_pts;

endpackage

/* rtl/cbez_if.sv */
// ============================================================================
// cbez_if: valid/ready channels of the cubic Bezier point evaluator
// Parameter input, point output and register write channels.
// ============================================================================
interface cbez_t_if;
    logic        valid;
    logic        ready;
    logic [16:0] param_t;

    modport source (output valid, output param_t, input ready);
    modport sink   (input valid, input param_t, output ready);
endinterface

interface cbez_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] curve_x;
    logic signed [15:0] curve_y;

    modport source (output valid, output curve_x, output curve_y, input ready);
    modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

interface cbez_cfg_if;
    logic               valid;
    logic               ready;
    logic [2:0]         index;
    logic signed [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/cbez_cfg_regs.sv */
// ============================================================================
// cbez_cfg_regs: control point register file
// Holds the four control points, written one coordinate per transfer.
// ============================================================================
module cbez_cfg_regs
    import cbez_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbez_cfg_if.sink    i_cfg_ch,
    output t_ctrl_pts   o_pts
);

    t_ctrl_pts r_pts;

    assign i_cfg_ch.ready = 1'b1;
    assign o_pts          = r_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= '0;
        end else if (i_cfg_ch.valid) begin
            case (t_reg_idx'(i_cfg_ch.index))
                REG_P0_X: r_pts.x[0] <= i_cfg_ch.data;
                REG_P0_Y: r_pts.y[0] <= i_cfg_ch.data;
                REG_P1_X: r_pts.x[1] <= i_cfg_ch.data;
                REG_P1_Y: r_pts.y[1] <= i_cfg_ch.data;
                REG_P2_X: r_pts.x[2] <= i_cfg_ch.data;
                REG_P2_Y: r_pts.y[2] <= i_cfg_ch.data;
                REG_P3_X: r_pts.x[3] <= i_cfg_ch.data;
                REG_P3_Y: r_pts.y[3] <= i_cfg_ch.data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/cbez_weight.sv */
// ============================================================================
// cbez_weight: Bernstein weight pipeline
// Three stages form (1-t)^3, 3t(1-t)^2, 3t^2(1-t) and t^3 at scale 2^48.
// ============================================================================
module cbez_weight
    import cbez_pkg::*;
(
    input  logic           i_clk,
    input  logic [2:0]     i_en,
    input  logic [T_W-1:0] i_t,
    output t_weights       o_w
);

    logic [T_W-1:0] r_t1;
    logic [T_W-1:0] r_u1;
    logic [T_W:0]   r_t3x1;
    logic [T_W-1:0] n_t;

    logic [T_W-1:0]   r_t2;
    logic [T_W-1:0]   r_u2;
    logic [2*T_W-1:0] r_tt2;
    logic [2*T_W-1:0] r_uu2;
    logic [2*T_W:0]   r_tu3;

    logic [3*T_W-1:0] n_w0;
    logic [3*T_W-1:0] n_w3;
    logic [3*T_W:0]   n_w1;
    logic [3*T_W:0]   n_w2;
    t_weights         r_w;

    always_comb begin
        n_t = (i_t > ONE_Q16) ? ONE_Q16 : i_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t1   <= n_t;
            r_u1   <= ONE_Q16 - n_t;
            r_t3x1 <= {1'b0, n_t} + {n_t, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_tt2 <= {{T_W{1'b0}}, r_t1} * {{T_W{1'b0}}, r_t1};
            r_uu2 <= {{T_W{1'b0}}, r_u1} * {{T_W{1'b0}}, r_u1};
            r_tu3 <= {{T_W{1'b0}}, r_t3x1} * {{(T_W+1){1'b0}}, r_u1};
        end
    end

    always_comb begin
        n_w0 = {{T_W{1'b0}}, r_uu2} * {{(2*T_W){1'b0}}, r_u2};
        n_w3 = {{T_W{1'b0}}, r_tt2} * {{(2*T_W){1'b0}}, r_t2};
        n_w1 = {{T_W{1'b0}}, r_tu3} * {{(2*T_W+1){1'b0}}, r_u2};
        n_w2 = {{T_W{1'b0}}, r_tu3} * {{(2*T_W+1){1'b0}}, r_t2};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_w[0] <= n_w0[W_W-1:0];
            r_w[1] <= n_w1[W_W-1:0];
            r_w[2] <= n_w2[W_W-1:0];
            r_w[3] <= n_w3[W_W-1:0];
        end
    end

    assign o_w = r_w;

endmodule

/* rtl/cbez_blend.sv */
// ============================================================================
// cbez_blend: weighted sum of one coordinate
// Three stages multiply, add in pairs, then add, round and remove the bias.
// ============================================================================
module cbez_blend
    import cbez_pkg::*;
(
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  t_weights           i_w,
    input  t_coord4            i_coord,
    output logic [COORD_W-1:0] o_val
);

    logic [3:0][PROD_W:0]   n_full;
    logic [3:0][PROD_W-1:0] r_prod;
    logic [PROD_W:0]        n_sum_a;
    logic [PROD_W:0]        n_sum_b;
    logic [PROD_W-1:0]      r_sum_a;
    logic [PROD_W-1:0]      r_sum_b;
    logic [PROD_W+1:0]      n_total;
    logic [COORD_W-1:0]     n_round;
    logic [COORD_W-1:0]     r_val;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_full[i] = {{COORD_W{1'b0}}, i_w[i]}
                      * {{W_W{1'b0}}, ~i_coord[i][COORD_W-1], i_coord[i][COORD_W-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= n_full[i][PROD_W-1:0];
            end
        end
    end

    always_comb begin
        n_sum_a = {1'b0, r_prod[0]} + {1'b0, r_prod[1]};
        n_sum_b = {1'b0, r_prod[2]} + {1'b0, r_prod[3]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sum_a <= n_sum_a[PROD_W-1:0];
            r_sum_b <= n_sum_b[PROD_W-1:0];
        end
    end

    always_comb begin
        n_total = {2'b00, r_sum_a} + {2'b00, r_sum_b} + {2'b00, ROUND_HALF};
        n_round = n_total[PROD_W-1:PROD_W-COORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_val <= {~n_round[COORD_W-1], n_round[COORD_W-2:0]};
        end
    end

    assign o_val = r_val;

endmodule

/* rtl/cubic_bezier_point_eval_unit.sv */
// ============================================================================
// cubic_bezier_point_eval_unit: 2D cubic Bezier curve point evaluator
// Each input transfer passes the three weight stages, then the three blend stages, to the output.
// Throughput: one item per clock while the output is not stalled; six register stages, each with a valid bit.
// A stalled output holds its stage; bubbles ahead of it still fill up.
// Reset clears all stage valid bits and sets every control point to zero.
// ============================================================================
module cubic_bezier_point_eval_unit
    import cbez_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbez_t_if.sink    i_t_ch,
    cbez_cfg_if.sink  i_cfg_ch,
    cbez_pt_if.source o_pt_ch
);

    localparam int STAGES = 6;

    t_ctrl_pts          pts;
    t_weights           weights;
    logic [STAGES-1:0]  stage_en;
    logic [STAGES-1:0]  r_valid;
    logic [STAGES-1:0]  n_valid;
    logic [COORD_W-1:0] val_x;
    logic [COORD_W-1:0] val_y;

    always_comb begin
        stage_en[STAGES-1] = !r_valid[STAGES-1] || o_pt_ch.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
                n_valid[k] = (k == 0) ? i_t_ch.valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign i_t_ch.ready = stage_en[0];

    cbez_cfg_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_pts    (pts)
    );

    cbez_weight u_weight (
        .i_clk (i_clk),
        .i_en  (stage_en[2:0]),
        .i_t   (i_t_ch.param_t),
        .o_w   (weights)
    );

    cbez_blend u_blend_x (
        .i_clk   (i_clk),
        .i_en    (stage_en[5:3]),
        .i_w     (weights),
        .i_coord (pts.x),
        .o_val   (val_x)
    );

    cbez_blend u_blend_y (
        .i_clk   (i_clk),
        .i_en    (stage_en[5:3]),
        .i_w     (weights),
        .i_coord (pts.y),
        .o_val   (val_y)
    );

    assign o_pt_ch.valid   = r_valid[STAGES-1];
    assign o_pt_ch.curve_x = val_x;
    assign o_pt_ch.curve_y = val_y;

endmodule

/* rtl/cbez_checker.sv */
// ============================================================================
// cbez_checker: port-level checks of the cubic Bezier point evaluator
// Watches the top level's channels for reset, stall, latency, input acceptance and register write readiness.
// ============================================================================
module cbez_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_x,
    input logic [15:0] i_out_y,
    input logic        i_cfg_ready
);

    logic in_xfer;
    logic flow;

    assign in_xfer = i_in_valid && i_in_ready && i_rst_n;
    assign flow    = i_out_ready && i_rst_n;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_y)))
        else $error("Stalled result changed or dropped.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(in_xfer, 6) && $past(flow, 1) && $past(flow, 2) && $past(flow, 3)
            && $past(flow, 4) && $past(flow, 5)) |-> i_out_valid)
        else $error("Result missing six cycles after an input transfer.");

    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("Input refused while the output stage could move.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("Register write channel not ready.");

endmodule

bind cubic_bezier_point_eval_unit cbez_checker u_cbez_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_t_ch.valid),
    .i_in_ready  (i_t_ch.ready),
    .i_out_valid (o_pt_ch.valid),
    .i_out_ready (o_pt_ch.ready),
    .i_out_x     (o_pt_ch.curve_x),
    .i_out_y     (o_pt_ch.curve_y),
    .i_cfg_ready (i_cfg_ch.ready)
);
